// ===== hdl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared command codes, queue entry type and field widths for the I2C master
// bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // Command codes carried on the op field
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;
    localparam logic [2:0] CMD_WAIT  = 3'd5;

    // Configuration register indexes
    localparam logic CFG_PHASE_TICKS = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    localparam int CFG_W       = 16;
    localparam int IN_DATA_W   = 16;
    localparam int IN_USER_W   = 3;
    localparam int OUT_DATA_W  = 16;

    // One classified tick waiting for the engine
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] write_byte;
        logic       answer_ack;
        logic       check_ack;
        logic       sda_sample;
    } t_tick;

endpackage

// ===== hdl/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// i2cm_front
// Input side: takes ticks from the stream slave, maps undefined op codes to
// no command and hands the classified tick to the queue.
// ----------------------------------------------------------------------------
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [IN_DATA_W-1:0] i_s_axis_tdata,  // write_byte[7:0], answer_ack,
                                                  // check_ack, sda_sample, pad
    input  logic [IN_USER_W-1:0] i_s_axis_tuser,  // op[2:0]
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_tick                o_tick
);

    logic [2:0] w_cmd;

    // Classify the op code; codes above wait ack carry no command
    always_comb begin
        case (i_s_axis_tuser)
            CMD_START, CMD_STOP, CMD_WRITE, CMD_READ, CMD_WAIT: begin
                w_cmd = i_s_axis_tuser;
            end
            default: begin
                w_cmd = CMD_NONE;
            end
        endcase
    end

    assign o_s_axis_tready   = ~i_q_full;
    assign o_push            = i_s_axis_tvalid & ~i_q_full;
    assign o_tick.cmd        = w_cmd;
    assign o_tick.write_byte = i_s_axis_tdata[7:0];
    assign o_tick.answer_ack = i_s_axis_tdata[8];
    assign o_tick.check_ack  = i_s_axis_tdata[9];
    assign o_tick.sda_sample = i_s_axis_tdata[10];

endmodule

// ===== hdl/i2cm_queue.sv =====
// ----------------------------------------------------------------------------
// i2cm_queue
// Four-entry request queue between the front and the engine.
// ----------------------------------------------------------------------------
module i2cm_queue
    import i2cm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_tick i_tick,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_avail,
    output t_tick o_tick
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_tick            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             w_do_pop;

    assign o_full   = (r_count == (PTR_W+1)'(DEPTH));
    assign o_avail  = (r_count != '0);
    assign o_tick   = r_mem[r_rd_ptr];
    assign w_do_pop = i_pop & o_avail;

    // Store incoming requests
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_tick;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Fill count stays within the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PTR_W+1)'(DEPTH))
        else $error("queue count beyond depth");

    // Pointers stay consistent with the fill count
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[PTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

// ===== hdl/i2cm_engine.sv =====
// ----------------------------------------------------------------------------
// i2cm_engine
// Back end: runs one bus sequencer step per popped tick and registers the
// resulting pin levels and status for the stream master.
// ----------------------------------------------------------------------------
module i2cm_engine
    import i2cm_pkg::*;
#(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_avail,
    input  t_tick                 i_tick,
    output logic                  o_pop,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int CW   = COUNTER_WIDTH;
    localparam int CMPW = ((CW > CFG_W) ? CW : CFG_W) + 1;
    localparam logic [CW:0]   NEXT_MAX = {1'b0, {CW{1'b1}}};
    localparam logic [CW-1:0] CNT_MAX  = {CW{1'b1}};

    // Phase step codes
    localparam logic [2:0] PH_0 = 3'd0;
    localparam logic [2:0] PH_1 = 3'd1;
    localparam logic [2:0] PH_2 = 3'd2;
    localparam logic [2:0] PH_3 = 3'd3;
    localparam logic [2:0] PH_4 = 3'd4;

    logic [CFG_W-1:0] r_phase_ticks;
    logic [CFG_W-1:0] r_ack_timeout;

    logic [2:0]    r_cmd,      n_cmd;
    logic [2:0]    r_phase,    n_phase;
    logic [2:0]    r_bit,      n_bit;
    logic [7:0]    r_shift,    n_shift;
    logic [CW-1:0] r_div,      n_div;
    logic [CW-1:0] r_poll,     n_poll;
    logic          r_ack_sel,  n_ack_sel;
    logic          r_scl,      n_scl;
    logic          r_sda,      n_sda;
    logic          r_sda_en,   n_sda_en;
    logic [7:0]    r_last_rd,  n_last_rd;
    logic          r_no_ack,   n_no_ack;
    logic          w_done;
    logic [CW:0]   w_next;
    logic          w_phase_end;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    assign o_pop           = i_avail & (~r_out_valid | i_m_axis_tready);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign w_next      = {1'b0, r_div} + 1'b1;
    assign w_phase_end = (CMPW'(w_next) >= CMPW'(r_phase_ticks)) || (w_next >= NEXT_MAX);

    // Next state of the bus sequencer for one tick
    always_comb begin
        n_cmd     = r_cmd;
        n_phase   = r_phase;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_div     = r_div;
        n_poll    = r_poll;
        n_ack_sel = r_ack_sel;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_sda_en  = r_sda_en;
        n_last_rd = r_last_rd;
        n_no_ack  = r_no_ack;
        w_done    = 1'b0;

        if (r_cmd == CMD_NONE) begin
            // Take a new command while idle
            if (i_tick.cmd != CMD_NONE) begin
                n_cmd   = i_tick.cmd;
                n_phase = PH_0;
                n_bit   = '0;
                n_div   = '0;
                case (i_tick.cmd)
                    CMD_START: begin
                        n_scl = 1'b1; n_sda = 1'b1; n_sda_en = 1'b1;
                    end
                    CMD_STOP: begin
                        n_scl = 1'b0; n_sda = 1'b0; n_sda_en = 1'b1;
                    end
                    CMD_WRITE: begin
                        n_shift = i_tick.write_byte;
                        n_scl = 1'b0; n_sda = i_tick.write_byte[7]; n_sda_en = 1'b1;
                    end
                    CMD_READ: begin
                        n_ack_sel = i_tick.answer_ack;
                        n_shift   = '0;
                        n_scl = 1'b0; n_sda = 1'b1; n_sda_en = 1'b0;
                    end
                    default: begin
                        n_ack_sel = i_tick.check_ack;
                        n_scl = 1'b0; n_sda = 1'b1; n_sda_en = 1'b0;
                    end
                endcase
            end
        end else if (r_cmd == CMD_WAIT && r_phase == PH_2) begin
            // Poll SDA for the acknowledge
            if (!r_ack_sel || CMPW'(r_poll) >= CMPW'(r_ack_timeout) || r_poll == CNT_MAX) begin
                n_scl    = 1'b0;
                n_no_ack = 1'b1;
                w_done   = 1'b1;
            end else begin
                n_poll = r_poll + 1'b1;
                if (!i_tick.sda_sample) begin
                    n_scl    = 1'b0;
                    n_no_ack = 1'b0;
                    w_done   = 1'b1;
                end
            end
        end else if (!w_phase_end) begin
            n_div = w_next[CW-1:0];
        end else begin
            // Phase over: drive the next bus level
            n_div = '0;
            case (r_cmd)
                CMD_START: begin
                    if (r_phase == PH_0) begin
                        n_sda = 1'b0; n_phase = PH_1;
                    end else begin
                        n_scl = 1'b0; w_done = 1'b1;
                    end
                end
                CMD_STOP: begin
                    if (r_phase == PH_0) begin
                        n_scl = 1'b1; n_sda = 1'b1; n_phase = PH_1;
                    end else begin
                        w_done = 1'b1;
                    end
                end
                CMD_WRITE: begin
                    if (r_phase == PH_0) begin
                        n_scl = 1'b1; n_phase = PH_1;
                    end else if (r_phase == PH_1) begin
                        n_scl = 1'b0; n_phase = PH_2;
                    end else if (r_bit != 3'd7) begin
                        n_bit   = r_bit + 1'b1;
                        n_shift = {r_shift[6:0], 1'b0};
                        n_sda   = r_shift[6];
                        n_phase = PH_0;
                    end else begin
                        w_done = 1'b1;
                    end
                end
                CMD_READ: begin
                    case (r_phase)
                        PH_0: begin
                            n_scl   = 1'b1;
                            n_shift = {r_shift[6:0], i_tick.sda_sample};
                            n_phase = PH_1;
                        end
                        PH_1: begin
                            n_scl = 1'b0;
                            if (r_bit != 3'd7) begin
                                n_bit   = r_bit + 1'b1;
                                n_phase = PH_0;
                            end else begin
                                n_sda     = ~r_ack_sel;
                                n_sda_en  = 1'b1;
                                n_last_rd = r_shift;
                                n_phase   = PH_2;
                            end
                        end
                        PH_2: begin
                            n_scl = 1'b1; n_phase = PH_3;
                        end
                        PH_3: begin
                            n_scl = 1'b0; n_phase = PH_4;
                        end
                        default: begin
                            n_sda = 1'b0; w_done = 1'b1;
                        end
                    endcase
                end
                CMD_WAIT: begin
                    if (r_phase == PH_0) begin
                        n_scl = 1'b1; n_phase = PH_1;
                    end else begin
                        n_poll  = '0;
                        n_phase = PH_2;
                    end
                end
                default: begin
                    w_done = 1'b1;
                end
            endcase
        end

        // Drop back to idle on completion
        if (w_done) begin
            n_cmd   = CMD_NONE;
            n_phase = PH_0;
            n_div   = '0;
        end
    end

    // Hold configuration and sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= CFG_W'(1);
            r_ack_timeout <= CFG_W'(250);
            r_cmd         <= CMD_NONE;
            r_phase       <= PH_0;
            r_bit         <= '0;
            r_shift       <= '0;
            r_div         <= '0;
            r_poll        <= '0;
            r_ack_sel     <= 1'b0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_sda_en      <= 1'b0;
            r_last_rd     <= '0;
            r_no_ack      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PHASE_TICKS) begin
                    r_phase_ticks <= i_cfg_data;
                end else begin
                    r_ack_timeout <= i_cfg_data;
                end
            end
            if (o_pop) begin
                r_cmd     <= n_cmd;
                r_phase   <= n_phase;
                r_bit     <= n_bit;
                r_shift   <= n_shift;
                r_div     <= n_div;
                r_poll    <= n_poll;
                r_ack_sel <= n_ack_sel;
                r_scl     <= n_scl;
                r_sda     <= n_sda;
                r_sda_en  <= n_sda_en;
                r_last_rd <= n_last_rd;
                r_no_ack  <= n_no_ack;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Register the result of each step
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= {2'b00, n_no_ack, n_last_rd, w_done, (n_cmd != CMD_NONE),
                           n_sda_en, n_sda, n_scl};
        end
    end

    // Idle engine keeps phase and divider cleared
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd == CMD_NONE) |-> (r_phase == PH_0 && r_div == '0))
        else $error("idle engine with phase or divider set");

    // Phase step never passes the last read phase
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_4)
        else $error("phase step out of range");

    // No step is taken while a result is stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_pop && r_out_valid && !i_m_axis_tready))
        else $error("result overwritten while stalled");

    // A reported completion leaves the engine idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && w_done) |=> (r_cmd == CMD_NONE))
        else $error("engine busy after completion");

endmodule

// ===== hdl/i2c_master_bit_engine_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_top
// Tick-driven I2C master bit engine: start, stop, byte write, byte read with
// ACK/NACK, and acknowledge wait with timeout.
//
//   Channel      Dir  Handshake                 Payload
//   s_axis       in   tvalid / tready           tdata: tick fields, tuser: op
//   m_axis       out  tvalid / tready           tdata: pin levels and status
//   cfg          in   i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
// One tick is accepted every cycle while the queue has room; each yields one
// result, held first in the request queue and then in the step register.
// The sequencer advances one step per tick, so the rate is set by its
// combinational next-state logic. Reset is synchronous, active low, and
// restores idle pins (SCL high, SDA released). Stalls on the master side
// fill the four-entry queue before the slave side drops tready.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_top
    import i2cm_pkg::*;
#(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // write_byte[7:0], answer_ack,
                                                   // check_ack, sda_sample, 5'b0
    input  logic [IN_USER_W-1:0]  i_s_axis_tuser,  // op[2:0]
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // scl_level, sda_level, sda_enable,
                                                   // busy_res, done_res, read_data[7:0],
                                                   // no_ack, 2'b0
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    logic  w_q_full;
    logic  w_push;
    t_tick w_in_tick;
    logic  w_pop;
    logic  w_avail;
    t_tick w_q_tick;

    i2cm_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_full        (w_q_full),
        .o_push          (w_push),
        .o_tick          (w_in_tick)
    );

    i2cm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_tick  (w_in_tick),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_avail (w_avail),
        .o_tick  (w_q_tick)
    );

    i2cm_engine #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_avail         (w_avail),
        .i_tick          (w_q_tick),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule
